[hw/rtl/trd_pkg.sv]
// Shared types, constants and helpers for the run-length pixel decoder.
package trd_pkg;

	localparam logic [6:0] COUNT_MASK = 7'h7F;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic REG_BPP    = 1'b0;
	localparam logic REG_PIXELS = 1'b1;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXEL  = 2'd1,
		PH_ERROR  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  run_length;
		logic        image_done;
		logic        run_error;
	} result_t;

	// Zero behaves as one byte and codes above four behave as four.
	function automatic logic [2:0] eff_bpp(input logic [2:0] bpp);
		logic [2:0] r;
		begin
			if (bpp == 3'd0) begin
				r = 3'd1;
			end else if (bpp > 3'd4) begin
				r = 3'd4;
			end else begin
				r = bpp;
			end
			return r;
		end
	endfunction

endpackage

[hw/rtl/tga_rle_pixel_decoder_core.sv]
// Top level of the run-length pixel decoder.
// The decoder takes one compressed byte per clock cycle and never needs a pause of its
// own: header and pixel bytes are each handled in the cycle they are accepted, and a
// finished pixel word enters a four-word output queue at that same edge, so it can be
// taken on the next cycle. in_stall rises only while that queue is full, so a stalled
// output side holds off input after four words are waiting. The decoder's state
// resets directly with no clearing pass. Writes to the two registers should be made
// while no word is waiting; an image_pixels write reloads the remaining-pixel count.
module tga_rle_pixel_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_value,
	output logic [7:0]  run_length,
	output logic        image_done,
	output logic        run_error
);
	import trd_pkg::*;

	logic    accept;
	logic    push;
	logic    full;
	result_t push_word;
	result_t out_word;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	trd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.push_word (push_word)
	);

	trd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign pixel_value = out_word.pixel_value;
	assign run_length  = out_word.run_length;
	assign image_done  = out_word.image_done;
	assign run_error   = out_word.run_error;

endmodule

[hw/rtl/trd_front.sv]
// Front end: takes stream bytes, tracks packets and pixel counts, and forms result words.
module trd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [31:0]      wr_data,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	output logic             push,
	output trd_pkg::result_t push_word
);
	import trd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] gather_q, gather_d;
	logic [7:0]  pkt_q, pkt_d;
	logic [7:0]  rep_q, rep_d;
	logic [31:0] left_q, left_d;
	logic [2:0]  bpp_q;
	logic [31:0] pixels_q;

	logic [7:0]  count;
	logic [31:0] count_wide;
	logic [31:0] gathered;
	logic        pixel_complete;

	assign count          = 8'd1 + {1'b0, data_byte[6:0] & COUNT_MASK};
	assign count_wide     = {24'd0, count};
	assign gathered       = gather_q | ({24'd0, data_byte} << {pos_q, 3'b000});
	assign pixel_complete = ({1'b0, pos_q} + 3'd1) >= eff_bpp(bpp_q);

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		gather_d  = gather_q;
		pkt_d     = pkt_q;
		rep_d     = rep_q;
		left_d    = left_q;
		push      = 1'b0;
		push_word = '0;
		if (accept) begin
			case (phase_q)
				PH_ERROR: begin
					push                 = 1'b1;
					push_word.run_length = rep_q;
					push_word.run_error  = 1'b1;
				end
				PH_HEADER: begin
					if (count_wide > left_q) begin
						phase_d              = PH_ERROR;
						rep_d                = count;
						push                 = 1'b1;
						push_word.run_length = count;
						push_word.run_error  = 1'b1;
					end else begin
						left_d = left_q - count_wide;
						if (data_byte[7]) begin
							pkt_d = 8'd1;
							rep_d = count;
						end else begin
							pkt_d = count;
							rep_d = 8'd1;
						end
						phase_d  = PH_PIXEL;
						pos_d    = 2'd0;
						gather_d = '0;
					end
				end
				PH_PIXEL: begin
					if (pixel_complete) begin
						push                  = 1'b1;
						push_word.pixel_value = gathered;
						push_word.run_length  = rep_q;
						pos_d                 = 2'd0;
						gather_d              = '0;
						pkt_d                 = pkt_q - 8'd1;
						// The packet ends when its count steps down from one to zero.
						if (pkt_q == 8'd1) begin
							phase_d = PH_HEADER;
							if (left_q == '0) begin
								push_word.image_done = 1'b1;
								left_d               = pixels_q;
							end
						end
					end else begin
						pos_d    = pos_q + 2'd1;
						gather_d = gathered;
					end
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end
		if (wr_en && wr_index == REG_PIXELS) begin
			left_d = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			gather_q <= '0;
			pkt_q    <= '0;
			rep_q    <= '0;
			left_q   <= 32'd1;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			gather_q <= gather_d;
			pkt_q    <= pkt_d;
			rep_q    <= rep_d;
			left_q   <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= 3'd4;
			pixels_q <= 32'd1;
		end else if (wr_en) begin
			if (wr_index == REG_BPP) begin
				bpp_q <= wr_data[2:0];
			end else begin
				pixels_q <= wr_data;
			end
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase was left without reset");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_word.run_error |-> push_word.pixel_value == '0 && !push_word.image_done)
		else $error("error word carries pixel data or image done");

	a_header_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_HEADER |-> !push || push_word.run_error)
		else $error("header byte produced a pixel word");

endmodule

[hw/rtl/trd_fifo.sv]
// Back end: a short queue of result words that drives the output channel.
module trd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  trd_pkg::result_t push_word,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output trd_pkg::result_t out_word
);
	import trd_pkg::*;

	result_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign full      = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign out_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("word pushed into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == FIFO_CNT_W'(1) && pop && !push |=> !out_valid)
		else $error("queue still valid after last word left");

endmodule
